[src/frct_pkg.sv]
// Shared types, constants and media format table for the floppy CHS translator.
`timescale 1ns / 1ps

package frct_pkg;

    localparam int MEDIA_TYPES = 8;

    localparam int CMD_W    = 2;
    localparam int DRV_W    = 2;
    localparam int MT_W     = 3;
    localparam int BLK_W    = 16;
    localparam int TRK_W    = 8;
    localparam int SECT_W   = 6;
    localparam int CYL_W    = 7;
    localparam int SPEC_W   = 8;
    localparam int RATE_W   = 2;
    localparam int GAP_W    = 8;

    // serial divider: 16-bit dividend, 8-bit divisor, one quotient bit per cycle
    localparam int DIV_W     = BLK_W;
    localparam int DIVR_W    = 8;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [TRK_W-1:0] HEAD_UNKNOWN = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST   = 2'd0,
        CMD_SEEK_DONE = 2'd1,
        CMD_RECAL     = 2'd2,
        CMD_RESET     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_SECT,
        ST_DIV_HEAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [BLK_W-1:0]  size;
        logic [SECT_W-1:0] sect;
        logic [DIVR_W-1:0] heads;
        logic              stretch;
        logic [GAP_W-1:0]  gap;
        logic [RATE_W-1:0] rate;
        logic [SPEC_W-1:0] spec;
    } media_fmt_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic              status;
        logic [SECT_W-1:0] sector_on_track;
        logic              head_select;
        logic [CYL_W-1:0]  cylinder;
        logic [TRK_W-1:0]  seek_cylinder;
        logic              need_seek;
        logic              need_specify;
        logic [SPEC_W-1:0] specify_byte;
        logic              need_rate;
        logic [RATE_W-1:0] rate_code;
        logic [GAP_W-1:0]  gap_length;
        logic [SECT_W-1:0] sectors_per_track;
    } result_t;

    function automatic media_fmt_t media_lookup(input logic [MT_W-1:0] mt);
        media_fmt_t f;
        f = '0;
        unique case (mt)
            3'd1: f = '{16'd720,  6'd9,  8'd2, 1'b0, 8'h2A, 2'd2, 8'hDF};
            3'd2: f = '{16'd2400, 6'd15, 8'd2, 1'b0, 8'h1B, 2'd0, 8'hDF};
            3'd3: f = '{16'd720,  6'd9,  8'd2, 1'b1, 8'h2A, 2'd2, 8'hDF};
            3'd4: f = '{16'd1440, 6'd9,  8'd2, 1'b0, 8'h2A, 2'd2, 8'hDF};
            3'd5: f = '{16'd720,  6'd9,  8'd2, 1'b1, 8'h23, 2'd1, 8'hDF};
            3'd6: f = '{16'd1440, 6'd9,  8'd2, 1'b0, 8'h23, 2'd1, 8'hDF};
            3'd7: f = '{16'd2880, 6'd18, 8'd2, 1'b0, 8'h1B, 2'd0, 8'hCF};
            default: f = '0;  // untested media
        endcase
        return f;
    endfunction

endpackage

[src/frct_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module frct_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  frct_pkg::div_ctrl_t         ctrl,
    input  logic [frct_pkg::DIV_W-1:0]  dividend,
    input  logic [frct_pkg::DIVR_W-1:0] divisor,
    output frct_pkg::div_status_t       status,
    output logic [frct_pkg::DIV_W-1:0]  quotient,
    output logic [frct_pkg::DIVR_W-1:0] remainder
);
    import frct_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIVR_W-1:0]    dvs_reg, dvs_next;
    logic [DIVR_W:0]      rem_sh;
    logic [DIVR_W:0]      diff;
    logic                 ge;

    always_comb begin
        // shift next dividend bit into the partial remainder
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = (rem_sh >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

[src/floppy_request_chs_translator_unit.sv]
// Top level: floppy request to cylinder/head/sector translator with cached controller state.
`timescale 1ns / 1ps

// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------------
// input     | s_valid / s_ready  | s_cmd, s_drive_number, s_media_type,
//           |                    | s_start_sector, s_reported_track
// result    | m_valid / m_ready  | m_status ... m_sectors_per_track (one per request)
//
// Events (seek done, recalibrate, controller reset) give no item.
// A request runs two passes of the bit-serial divider, block / sectors then
// track / heads, then writes its result in ST_OUT once the output register is free;
// the next item is taken only back in ST_IDLE, never while a request is in flight.
// A rejected request skips the divider and goes straight to ST_OUT.
// The result sits in an output register; a new item is taken while it waits, and
// the next result waits only for that register to drain.
// aresetn is synchronous and active low; head position resets to unknown (255).
module floppy_request_chs_translator_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [frct_pkg::CMD_W-1:0]   s_cmd,
    input  logic [frct_pkg::DRV_W-1:0]   s_drive_number,
    input  logic [frct_pkg::MT_W-1:0]    s_media_type,
    input  logic [frct_pkg::BLK_W-1:0]   s_start_sector,
    input  logic [frct_pkg::TRK_W-1:0]   s_reported_track,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic [frct_pkg::SECT_W-1:0]  m_sector_on_track,
    output logic                         m_head_select,
    output logic [frct_pkg::CYL_W-1:0]   m_cylinder,
    output logic [frct_pkg::TRK_W-1:0]   m_seek_cylinder,
    output logic                         m_need_seek,
    output logic                         m_need_specify,
    output logic [frct_pkg::SPEC_W-1:0]  m_specify_byte,
    output logic                         m_need_rate,
    output logic [frct_pkg::RATE_W-1:0]  m_rate_code,
    output logic [frct_pkg::GAP_W-1:0]   m_gap_length,
    output logic [frct_pkg::SECT_W-1:0]  m_sectors_per_track
);
    import frct_pkg::*;

    state_t state_reg, state_next;

    // tracked controller state
    logic [DRV_W-1:0]  last_drive_reg, last_drive_next;
    logic [TRK_W-1:0]  head_pos_reg, head_pos_next;
    logic              spec_known_reg, spec_known_next;
    logic [SPEC_W-1:0] last_spec_reg, last_spec_next;
    logic              rate_known_reg, rate_known_next;
    logic [RATE_W-1:0] last_rate_reg, last_rate_next;

    // request in flight
    logic [MT_W-1:0]   mt_reg, mt_next;
    logic              drv_chg_reg, drv_chg_next;
    logic              reject_reg, reject_next;
    logic [SECT_W-1:0] sec_reg, sec_next;
    logic              head_reg, head_next;
    logic [TRK_W-1:0]  cyl_reg, cyl_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    result_t           out_reg, out_next;

    media_fmt_t        in_fmt, cur_fmt;
    logic              accept;
    logic              in_reject;
    logic [TRK_W-1:0]  seekc;

    div_ctrl_t         div_ctrl;
    div_status_t       div_stat;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic [DIV_W-1:0]  div_quo;
    logic [DIVR_W-1:0] div_rem;

    frct_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign in_fmt  = media_lookup(s_media_type);
    assign cur_fmt = media_lookup(mt_reg);

    // unlisted media, empty table row, or block running past the disk end
    assign in_reject = (int'(s_media_type) >= MEDIA_TYPES)
                    || (in_fmt.size == '0) || (in_fmt.sect == '0) || (in_fmt.heads == '0)
                    || (({1'b0, s_start_sector} + (BLK_W+1)'(2)) > {1'b0, in_fmt.size});

    // cylinder shifted left once for stretched media, kept to 8 bits
    assign seekc = cur_fmt.stretch ? {cyl_reg[TRK_W-2:0], 1'b0} : cyl_reg;

    always_comb begin
        state_next      = state_reg;
        last_drive_next = last_drive_reg;
        head_pos_next   = head_pos_reg;
        spec_known_next = spec_known_reg;
        last_spec_next  = last_spec_reg;
        rate_known_next = rate_known_reg;
        last_rate_next  = last_rate_reg;
        mt_next         = mt_reg;
        drv_chg_next    = drv_chg_reg;
        reject_next     = reject_reg;
        sec_next        = sec_reg;
        head_next       = head_reg;
        cyl_next        = cyl_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        div_ctrl.start  = 1'b0;
        div_dividend    = s_start_sector;
        div_divisor     = {{(DIVR_W-SECT_W){1'b0}}, in_fmt.sect};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd_t'(s_cmd))
                        CMD_REQUEST: begin
                            mt_next         = s_media_type;
                            drv_chg_next    = (s_drive_number != last_drive_reg);
                            last_drive_next = s_drive_number;
                            reject_next     = in_reject;
                            if (in_reject) begin
                                state_next = ST_OUT;
                            end else begin
                                div_ctrl.start = 1'b1;
                                state_next     = ST_DIV_SECT;
                            end
                        end
                        CMD_SEEK_DONE: head_pos_next = s_reported_track;
                        CMD_RECAL:     head_pos_next = '0;
                        CMD_RESET: begin
                            spec_known_next = 1'b0;
                            rate_known_next = 1'b0;
                            head_pos_next   = HEAD_UNKNOWN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV_SECT: begin
                // block / sectors: remainder is the sector, quotient the track
                div_dividend = div_quo;
                div_divisor  = cur_fmt.heads;
                if (div_stat.done) begin
                    sec_next       = div_rem[SECT_W-1:0];
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV_HEAD;
                end
            end
            ST_DIV_HEAD: begin
                // track / heads: remainder is the head, quotient the cylinder
                div_dividend = div_quo;
                div_divisor  = cur_fmt.heads;
                if (div_stat.done) begin
                    head_next  = div_rem[0];
                    cyl_next   = div_quo[TRK_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_next     = '0;
                    state_next   = ST_IDLE;
                    if (reject_reg) begin
                        out_next.status = 1'b1;
                    end else begin
                        out_next.sector_on_track   = sec_reg + SECT_W'(1);
                        out_next.head_select       = head_reg;
                        out_next.cylinder          = cyl_reg[CYL_W-1:0];
                        out_next.seek_cylinder     = seekc;
                        out_next.need_seek         = drv_chg_reg || (seekc != head_pos_reg);
                        out_next.need_specify      = !spec_known_reg
                                                  || (last_spec_reg != cur_fmt.spec);
                        out_next.specify_byte      = cur_fmt.spec;
                        out_next.need_rate         = !rate_known_reg
                                                  || (last_rate_reg != cur_fmt.rate);
                        out_next.rate_code         = cur_fmt.rate;
                        out_next.gap_length        = cur_fmt.gap;
                        out_next.sectors_per_track = cur_fmt.sect;
                        // settings now count as sent
                        spec_known_next = 1'b1;
                        last_spec_next  = cur_fmt.spec;
                        rate_known_next = 1'b1;
                        last_rate_next  = cur_fmt.rate;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_drive_reg <= '0;
            head_pos_reg   <= HEAD_UNKNOWN;
            spec_known_reg <= 1'b0;
            last_spec_reg  <= '0;
            rate_known_reg <= 1'b0;
            last_rate_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_drive_reg <= last_drive_next;
            head_pos_reg   <= head_pos_next;
            spec_known_reg <= spec_known_next;
            last_spec_reg  <= last_spec_next;
            rate_known_reg <= rate_known_next;
            last_rate_reg  <= last_rate_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mt_reg      <= mt_next;
        drv_chg_reg <= drv_chg_next;
        reject_reg  <= reject_next;
        sec_reg     <= sec_next;
        head_reg    <= head_next;
        cyl_reg     <= cyl_next;
        out_reg     <= out_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = out_reg.status;
    assign m_sector_on_track   = out_reg.sector_on_track;
    assign m_head_select       = out_reg.head_select;
    assign m_cylinder          = out_reg.cylinder;
    assign m_seek_cylinder     = out_reg.seek_cylinder;
    assign m_need_seek         = out_reg.need_seek;
    assign m_need_specify      = out_reg.need_specify;
    assign m_specify_byte      = out_reg.specify_byte;
    assign m_need_rate         = out_reg.need_rate;
    assign m_rate_code         = out_reg.rate_code;
    assign m_gap_length        = out_reg.gap_length;
    assign m_sectors_per_track = out_reg.sectors_per_track;

endmodule

[tb/floppy_request_chs_translator_unit_tb.sv]
// Self-checking testbench for the floppy request to cylinder/head/sector translator.
`timescale 1ns / 1ps

module floppy_request_chs_translator_unit_tb;

    import frct_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int RANDOM_ITEMS  = 800;
    localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
    localparam int STALL_LIMIT   = 4000;  // cycles with no item moving on either side
    localparam int SETTLE_CYCLES = 100;   // settle time after the last result, in cycles
    localparam int PRINT_CAP     = 40;

    // One input item as the sender holds it
    typedef struct packed {
        cmd_t              cmd;
        logic [DRV_W-1:0]  drv;
        logic [MT_W-1:0]   mt;
        logic [BLK_W-1:0]  blk;
        logic [TRK_W-1:0]  trk;
    } fl_item_t;

    // One row of the media format table
    typedef struct packed {
        bit [15:0] size;
        bit [5:0]  sect;
        bit [1:0]  heads;
        bit        stretch;
        bit [7:0]  gap;
        bit [1:0]  rate;
        bit [7:0]  spec;
    } fmt_row_t;

    // Geometry of one block on one medium
    typedef struct packed {
        bit [7:0]  sec;
        bit [7:0]  head;
        bit [15:0] cyl;
        bit [7:0]  seekc;
    } chs_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;

    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd            = '0;
    logic [DRV_W-1:0]    s_drive_number   = '0;
    logic [MT_W-1:0]     s_media_type     = '0;
    logic [BLK_W-1:0]    s_start_sector   = '0;
    logic [TRK_W-1:0]    s_reported_track = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_status;
    logic [SECT_W-1:0]   m_sector_on_track;
    logic                m_head_select;
    logic [CYL_W-1:0]    m_cylinder;
    logic [TRK_W-1:0]    m_seek_cylinder;
    logic                m_need_seek;
    logic                m_need_specify;
    logic [SPEC_W-1:0]   m_specify_byte;
    logic                m_need_rate;
    logic [RATE_W-1:0]   m_rate_code;
    logic [GAP_W-1:0]    m_gap_length;
    logic [SECT_W-1:0]   m_sectors_per_track;

    floppy_request_chs_translator_unit DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_drive_number      (s_drive_number),
        .s_media_type        (s_media_type),
        .s_start_sector      (s_start_sector),
        .s_reported_track    (s_reported_track),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_sector_on_track   (m_sector_on_track),
        .m_head_select       (m_head_select),
        .m_cylinder          (m_cylinder),
        .m_seek_cylinder     (m_seek_cylinder),
        .m_need_seek         (m_need_seek),
        .m_need_specify      (m_need_specify),
        .m_specify_byte      (m_specify_byte),
        .m_need_rate         (m_need_rate),
        .m_rate_code         (m_rate_code),
        .m_gap_length        (m_gap_length),
        .m_sectors_per_track (m_sectors_per_track)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    fl_item_t    pending_items[$];      // items not yet offered
    result_t     expected_results[$];   // translations still owed by the DUT
    int unsigned n_total     = 0;
    int unsigned n_accepted  = 0;
    int unsigned mismatch_count = 0;

    // Translator state as the predictor tracks it
    logic [DRV_W-1:0]  pred_last_drive = '0;
    logic [TRK_W-1:0]  pred_head_pos   = HEAD_UNKNOWN;
    logic              pred_spec_known = 1'b0;
    logic [SPEC_W-1:0] pred_last_spec  = '0;
    logic              pred_rate_known = 1'b0;
    logic [RATE_W-1:0] pred_last_rate  = '0;

    task automatic note_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Media formats; row 0 is the untested medium and has no geometry.
    function automatic fmt_row_t media_row(input logic [MT_W-1:0] mt);
        fmt_row_t r;
        r = '0;
        case (mt)
            3'd1:    r = '{16'd720,  6'd9,  2'd2, 1'b0, 8'h2A, 2'd2, 8'hDF};
            3'd2:    r = '{16'd2400, 6'd15, 2'd2, 1'b0, 8'h1B, 2'd0, 8'hDF};
            3'd3:    r = '{16'd720,  6'd9,  2'd2, 1'b1, 8'h2A, 2'd2, 8'hDF};
            3'd4:    r = '{16'd1440, 6'd9,  2'd2, 1'b0, 8'h2A, 2'd2, 8'hDF};
            3'd5:    r = '{16'd720,  6'd9,  2'd2, 1'b1, 8'h23, 2'd1, 8'hDF};
            3'd6:    r = '{16'd1440, 6'd9,  2'd2, 1'b0, 8'h23, 2'd1, 8'hDF};
            3'd7:    r = '{16'd2880, 6'd18, 2'd2, 1'b0, 8'h1B, 2'd0, 8'hCF};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic chs_t block_geometry(input fmt_row_t f, input logic [BLK_W-1:0] blk);
        chs_t        g;
        int unsigned trk;
        int unsigned cyl;
        trk     = int'(blk) / int'(f.sect);
        cyl     = trk / int'(f.heads);
        g.sec   = 8'(int'(blk) % int'(f.sect));
        g.head  = 8'(trk % int'(f.heads));
        g.cyl   = 16'(cyl);
        g.seekc = 8'(cyl << f.stretch);
        return g;
    endfunction

    // Advance the tracked controller state by one item; requests owe one result.
    task automatic translate_item(input fl_item_t it);
        result_t  r;
        fmt_row_t f;
        chs_t     g;
        logic     drive_changed;
        case (it.cmd)
            CMD_SEEK_DONE: pred_head_pos = it.trk;
            CMD_RECAL:     pred_head_pos = '0;
            CMD_RESET: begin
                pred_spec_known = 1'b0;
                pred_rate_known = 1'b0;
                pred_head_pos   = HEAD_UNKNOWN;
            end
            default: begin
                r = '0;
                drive_changed   = (it.drv != pred_last_drive);
                pred_last_drive = it.drv;
                f = media_row(it.mt);
                if (int'(it.mt) >= MEDIA_TYPES || f.size == 0 || f.sect == 0 ||
                    f.heads == 0 || int'(it.blk) + 2 > int'(f.size)) begin
                    r.status = 1'b1;
                end else begin
                    g = block_geometry(f, it.blk);
                    r.sector_on_track   = SECT_W'(g.sec + 8'd1);
                    r.head_select       = g.head[0];
                    r.cylinder          = g.cyl[CYL_W-1:0];
                    r.seek_cylinder     = g.seekc;
                    r.need_seek         = drive_changed || (g.seekc != pred_head_pos);
                    r.need_specify      = !pred_spec_known || (pred_last_spec != f.spec);
                    r.specify_byte      = f.spec;
                    r.need_rate         = !pred_rate_known || (pred_last_rate != f.rate);
                    r.rate_code         = f.rate;
                    r.gap_length        = f.gap;
                    r.sectors_per_track = f.sect;
                    pred_spec_known = 1'b1;
                    pred_last_spec  = f.spec;
                    pred_rate_known = 1'b1;
                    pred_last_rate  = f.rate;
                end
                expected_results.push_back(r);
            end
        endcase
    endtask

    // Three idling regimes in order of progress through the item list.
    function automatic int unsigned idle_phase(input int unsigned done);
        if (done < n_total / 3)
            return 0;
        else if (done < (2 * n_total) / 3)
            return 1;
        return 2;
    endfunction

    task automatic queue_item(input cmd_t c, input int unsigned drv, input int unsigned mt,
                              input int unsigned blk, input int unsigned trk);
        fl_item_t it;
        it.cmd = c;
        it.drv = DRV_W'(drv);
        it.mt  = MT_W'(mt);
        it.blk = BLK_W'(blk);
        it.trk = TRK_W'(trk);
        pending_items.push_back(it);
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : main_seq
        int unsigned pick;
        int unsigned g_drv;
        int unsigned g_mt;
        int unsigned g_blk;
        int unsigned g_seekc;
        fmt_row_t    f;
        chs_t        g_geo;

        // Directed part: first request after reset sees an unknown head and
        // empty caches, so it must ask for seek, specify and rate.
        queue_item(CMD_REQUEST,   0, 1, 0,     0);
        queue_item(CMD_REQUEST,   0, 1, 0,     0);     // caches hit, head still unknown
        queue_item(CMD_RECAL,     0, 0, 0,     0);
        queue_item(CMD_REQUEST,   0, 1, 1,     0);     // head on track 0: no seek
        queue_item(CMD_REQUEST,   1, 1, 1,     0);     // drive change forces seek
        queue_item(CMD_REQUEST,   1, 7, 2878,  0);     // last legal block, new rate/specify
        queue_item(CMD_REQUEST,   1, 7, 2879,  0);     // one past the end
        queue_item(CMD_REQUEST,   3, 7, 65535, 255);   // top of the sector range
        queue_item(CMD_REQUEST,   2, 0, 0,     0);     // untested medium
        queue_item(CMD_SEEK_DONE, 0, 0, 0,     255);
        queue_item(CMD_REQUEST,   2, 3, 719,   0);     // stretched, past the end
        queue_item(CMD_REQUEST,   2, 3, 718,   0);     // stretched, seek track doubled
        queue_item(CMD_SEEK_DONE, 0, 0, 0,     78);
        queue_item(CMD_REQUEST,   2, 3, 718,   0);     // head already there
        queue_item(CMD_REQUEST,   2, 5, 718,   0);     // same track, rate changes
        queue_item(CMD_RESET,     3, 7, 65535, 255);
        queue_item(CMD_REQUEST,   2, 5, 718,   0);     // caches lost, head unknown
        queue_item(CMD_REQUEST,   0, 2, 2398,  170);
        queue_item(CMD_REQUEST,   0, 2, 2399,  0);
        queue_item(CMD_REQUEST,   0, 4, 1438,  0);
        queue_item(CMD_REQUEST,   1, 6, 100,   0);
        queue_item(CMD_SEEK_DONE, 0, 0, 0,     0);
        queue_item(CMD_REQUEST,   1, 6, 0,     0);
        queue_item(CMD_RECAL,     3, 7, 65535, 255);

        // Random part: mostly realistic request/seek sequences on a sticky
        // drive and medium, with boundary requests, noise and events mixed in.
        g_drv   = 0;
        g_mt    = 1;
        g_blk   = 0;
        g_seekc = 0;
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 20)
                g_drv = $urandom_range(0, 3);
            if ($urandom_range(0, 99) < 30)
                g_mt = $urandom_range(1, 7);
            f = media_row(MT_W'(g_mt));
            if (pick < 45) begin
                g_blk = $urandom_range(0, int'(f.size) - 2);
                queue_item(CMD_REQUEST, g_drv, g_mt, g_blk, $urandom_range(0, 255));
                g_geo   = block_geometry(f, BLK_W'(g_blk));
                g_seekc = g_geo.seekc;
            end else if (pick < 60) begin
                // mostly land the head where the last request wanted it
                if ($urandom_range(0, 99) < 75)
                    queue_item(CMD_SEEK_DONE, $urandom_range(0, 3), $urandom_range(0, 7),
                               $urandom_range(0, 65535), g_seekc);
                else
                    queue_item(CMD_SEEK_DONE, $urandom_range(0, 3), $urandom_range(0, 7),
                               $urandom_range(0, 65535), $urandom_range(0, 255));
            end else if (pick < 68) begin
                queue_item(CMD_RECAL, $urandom_range(0, 3), $urandom_range(0, 7),
                           $urandom_range(0, 65535), $urandom_range(0, 255));
            end else if (pick < 72) begin
                queue_item(CMD_RESET, $urandom_range(0, 3), $urandom_range(0, 7),
                           $urandom_range(0, 65535), $urandom_range(0, 255));
            end else if (pick < 82) begin
                // around the disk end: two legal, two rejected
                queue_item(CMD_REQUEST, g_drv, g_mt, int'(f.size) - $urandom_range(0, 3),
                           $urandom_range(0, 255));
            end else if (pick < 90) begin
                queue_item(CMD_REQUEST, $urandom_range(0, 3), $urandom_range(0, 7),
                           $urandom_range(0, 65535), $urandom_range(0, 255));
            end else begin
                // neighbor block, usually on the same track
                if (g_blk + 3 <= int'(f.size))
                    g_blk = g_blk + 1;
                queue_item(CMD_REQUEST, g_drv, g_mt, g_blk, $urandom_range(0, 255));
                g_geo   = block_geometry(f, BLK_W'(g_blk));
                g_seekc = g_geo.seekc;
            end
        end
        n_total = pending_items.size();

        // Synchronous reset, released once.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Everything accepted and every translation returned, then let the
        // pipeline settle so stray results still get caught.
        do @(negedge aclk);
        while (n_accepted != n_total || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued items; predicts each one at its acceptance.
    // ------------------------------------------------------------------
    fl_item_t cur_item;
    logic     drain_wait = 1'b0;
    logic     drain_done = 1'b0;

    always @(posedge aclk) begin : item_driver
        int unsigned idle_pct;
        logic        offer;
        fl_item_t    nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                translate_item(cur_item);
                n_accepted++;
            end
            // Slot is free: either nothing offered or the offer just went in.
            if (!s_valid || s_ready) begin
                offer = 1'b0;
                // once, hold the sender off until the DUT has drained completely
                if (!drain_done && n_accepted >= (3 * n_total) / 4) begin
                    drain_done = 1'b1;
                    drain_wait = 1'b1;
                end
                if (drain_wait && expected_results.size() == 0)
                    drain_wait = 1'b0;
                case (idle_phase(n_accepted))
                    0:       idle_pct = 13;
                    1:       idle_pct = 88;
                    default: idle_pct = 0;
                endcase
                if (!drain_wait && pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= idle_pct) begin
                    nxt      = pending_items.pop_front();
                    cur_item = nxt;
                    offer    = 1'b1;
                    s_cmd            <= nxt.cmd;
                    s_drive_number   <= nxt.drv;
                    s_media_type     <= nxt.mt;
                    s_start_sector   <= nxt.blk;
                    s_reported_track <= nxt.trk;
                end
                s_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest owed translation and
    // paces m_ready, including one long hold-off so the DUT backs up.
    // ------------------------------------------------------------------
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    always @(posedge aclk) begin : result_monitor
        result_t     want;
        int unsigned idle_pct;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("result with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("status",            m_status,            want.status);
                    check_field("sector_on_track",   m_sector_on_track,   want.sector_on_track);
                    check_field("head_select",       m_head_select,       want.head_select);
                    check_field("cylinder",          m_cylinder,          want.cylinder);
                    check_field("seek_cylinder",     m_seek_cylinder,     want.seek_cylinder);
                    check_field("need_seek",         m_need_seek,         want.need_seek);
                    check_field("need_specify",      m_need_specify,      want.need_specify);
                    check_field("specify_byte",      m_specify_byte,      want.specify_byte);
                    check_field("need_rate",         m_need_rate,         want.need_rate);
                    check_field("rate_code",         m_rate_code,         want.rate_code);
                    check_field("gap_length",        m_gap_length,        want.gap_length);
                    check_field("sectors_per_track", m_sectors_per_track,
                                want.sectors_per_track);
                end
            end
            // long receiver stall late in the run while the sender keeps offering
            if (!hold_done && n_accepted >= (5 * n_total) / 6) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            case (idle_phase(n_accepted))
                0:       idle_pct = 88;
                1:       idle_pct = 13;
                default: idle_pct = 0;
            endcase
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no item moving on either channel for too long ends the run.
    // ------------------------------------------------------------------
    int unsigned stall_cycles = 0;

    always @(posedge aclk) begin : stall_watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout: %0d of %0d items in, %0d results owed",
                         $time, n_accepted, n_total, expected_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
